/* sv/follower_two_motor_pwm_controller_assert.svh */
// ----------------------------------------------------------------------------
// follower assertion macros
// shared concurrent assertion forms, clocked on clk and held off by rst_n
// ----------------------------------------------------------------------------
`ifndef FOLLOWER_TWO_MOTOR_PWM_CONTROLLER_ASSERT_SVH
`define FOLLOWER_TWO_MOTOR_PWM_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define FTMPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FTMPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ftmpc_pkg.sv */
// ----------------------------------------------------------------------------
// ftmpc_pkg
// types and constants of the two-motor follower
// ----------------------------------------------------------------------------
package ftmpc_pkg;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_SAMPLE  = 2'd1,
    MODE_COMMAND = 2'd2,
    MODE_NOP     = 2'd3
  } mode_t;

  localparam logic [3:0] CMD_FLIP    = 4'b0011;
  localparam logic [3:0] CMD_CLOSER  = 4'b0110;
  localparam logic [3:0] CMD_FARTHER = 4'b1100;
  localparam logic [3:0] CMD_PARK    = 4'b1001;

  typedef enum logic [2:0] {
    REG_FOLLOW_POWER     = 3'd0,
    REG_BEACON_THRESHOLD = 3'd1,
    REG_TURN_MARGIN      = 3'd2,
    REG_SETPOINT_STEP    = 3'd3,
    REG_SETPOINT_MIN     = 3'd4,
    REG_SETPOINT_MAX     = 3'd5
  } reg_idx_t;

  localparam logic [6:0]  PHASE_TOP      = 7'd99;
  localparam logic [14:0] SENSE_BASE     = 15'd3000;
  localparam logic [11:0] SETPOINT_RESET = 12'd1200;
  localparam logic [11:0] SETPOINT_LIMIT = 12'd4095;

  localparam logic [6:0]  FOLLOW_POWER_RST     = 7'd50;
  localparam logic [12:0] BEACON_THRESHOLD_RST = 13'd200;
  localparam logic [11:0] TURN_MARGIN_RST      = 12'd300;
  localparam logic [11:0] SETPOINT_STEP_RST    = 12'd400;
  localparam logic [11:0] SETPOINT_MIN_RST     = 12'd400;
  localparam logic [11:0] SETPOINT_MAX_RST     = 12'd2800;

  typedef struct packed {
    mode_t       mode;
    logic [12:0] beacon_mv;
    logic [12:0] left_sensor_mv;
    logic [12:0] right_sensor_mv;
    logic [3:0]  command_code;
  } in_item_t;

  typedef struct packed {
    logic        m1_pos;
    logic        m1_neg;
    logic        m2_pos;
    logic        m2_neg;
    logic [6:0]  left_power_out;
    logic [6:0]  right_power_out;
    logic        left_forward_out;
    logic        right_forward_out;
    logic        reversed_out;
    logic [11:0] follow_setpoint;
    logic [31:0] distance_travelled;
  } out_item_t;

  // floor(half * 4 / 25) by reciprocal: 1311 / 2^15 is exact for half*4 up to 508
  function automatic logic [4:0] odo_increment(input logic [6:0] half);
    logic [19:0] prod;
    prod = 20'({half, 2'b00}) * 20'd1311;
    return prod[19:15];
  endfunction

endpackage

/* sv/ftmpc_if.sv */
// ----------------------------------------------------------------------------
// ftmpc channel interfaces
// valid/ready channels for the request and result streams
// ----------------------------------------------------------------------------
interface ftmpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [12:0] beacon_mv;
  logic [12:0] left_sensor_mv;
  logic [12:0] right_sensor_mv;
  logic [3:0]  command_code;

  modport source (output valid, mode, beacon_mv, left_sensor_mv, right_sensor_mv,
                  command_code, input ready);
  modport sink   (input valid, mode, beacon_mv, left_sensor_mv, right_sensor_mv,
                  command_code, output ready);
endinterface

interface ftmpc_out_if;
  logic        valid;
  logic        ready;
  logic        m1_pos;
  logic        m1_neg;
  logic        m2_pos;
  logic        m2_neg;
  logic [6:0]  left_power_out;
  logic [6:0]  right_power_out;
  logic        left_forward_out;
  logic        right_forward_out;
  logic        reversed_out;
  logic [11:0] follow_setpoint;
  logic [31:0] distance_travelled;

  modport source (output valid, m1_pos, m1_neg, m2_pos, m2_neg, left_power_out,
                  right_power_out, left_forward_out, right_forward_out, reversed_out,
                  follow_setpoint, distance_travelled, input ready);
  modport sink   (input valid, m1_pos, m1_neg, m2_pos, m2_neg, left_power_out,
                  right_power_out, left_forward_out, right_forward_out, reversed_out,
                  follow_setpoint, distance_travelled, output ready);
endinterface

/* sv/follower_two_motor_pwm_controller.sv */
// ----------------------------------------------------------------------------
// follower_two_motor_pwm_controller
// two-motor follower: pwm bridge drive, odometry, beacon following, commands
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake            | carries
//  ----------+-----------+----------------------+------------------------------
//  in_chan   | in        | valid/ready          | tick, sample or command request
//  out_chan  | out       | valid/ready          | pins, motor state, setpoint, odometer
//  cfg_*     | in        | apb, pready tied high| six follower registers
//
//  two register stages: input register, then state update into the result
//  register, from which out_chan presents the result of each accepted request
//  one request per cycle while out_chan.ready is high; the state update is combinational
//  synchronous active-low reset returns state, config and valid flags to defaults
//  a stalled result holds the result register; the input register fills, and
//  in_chan.ready drops when both stages are occupied and out_chan.ready is low
//
module follower_two_motor_pwm_controller
  import ftmpc_pkg::*;
#(
  parameter int PWM_STEP       = 5,
  parameter int ODOMETER_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  ftmpc_in_if.sink     in_chan,
  ftmpc_out_if.source  out_chan,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  `include "follower_two_motor_pwm_controller_assert.svh"

  localparam logic [7:0] STEP8 = 8'(PWM_STEP);

  // ---------------- configuration registers ----------------
  logic [6:0]  follow_power_r;
  logic [12:0] beacon_threshold_r;
  logic [11:0] turn_margin_r;
  logic [11:0] setpoint_step_r;
  logic [11:0] setpoint_min_r;
  logic [11:0] setpoint_max_r;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      follow_power_r     <= FOLLOW_POWER_RST;
      beacon_threshold_r <= BEACON_THRESHOLD_RST;
      turn_margin_r      <= TURN_MARGIN_RST;
      setpoint_step_r    <= SETPOINT_STEP_RST;
      setpoint_min_r     <= SETPOINT_MIN_RST;
      setpoint_max_r     <= SETPOINT_MAX_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FOLLOW_POWER:     follow_power_r     <= cfg_pwdata[6:0];
        REG_BEACON_THRESHOLD: beacon_threshold_r <= cfg_pwdata[12:0];
        REG_TURN_MARGIN:      turn_margin_r      <= cfg_pwdata[11:0];
        REG_SETPOINT_STEP:    setpoint_step_r    <= cfg_pwdata[11:0];
        REG_SETPOINT_MIN:     setpoint_min_r     <= cfg_pwdata[11:0];
        REG_SETPOINT_MAX:     setpoint_max_r     <= cfg_pwdata[11:0];
        default: ;  // addresses past the register list are dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FOLLOW_POWER:     cfg_prdata = 32'(follow_power_r);
      REG_BEACON_THRESHOLD: cfg_prdata = 32'(beacon_threshold_r);
      REG_TURN_MARGIN:      cfg_prdata = 32'(turn_margin_r);
      REG_SETPOINT_STEP:    cfg_prdata = 32'(setpoint_step_r);
      REG_SETPOINT_MIN:     cfg_prdata = 32'(setpoint_min_r);
      REG_SETPOINT_MAX:     cfg_prdata = 32'(setpoint_max_r);
      default:              cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic     out_valid_r;
  out_item_t out_item_r;
  logic     adv;       // input register moves into the result register
  logic     in_take;

  assign adv             = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready   = !s1_valid_r || adv;
  assign in_take         = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) s1_valid_r <= in_chan.valid;
      if (adv) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  // input register, payload only
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.mode            <= mode_t'(in_chan.mode);
      s1_item_r.beacon_mv       <= in_chan.beacon_mv;
      s1_item_r.left_sensor_mv  <= in_chan.left_sensor_mv;
      s1_item_r.right_sensor_mv <= in_chan.right_sensor_mv;
      s1_item_r.command_code    <= in_chan.command_code;
    end
  end

  // ---------------- follower state ----------------
  logic [6:0]                phase_r, phase_nxt;
  logic [6:0]                lpow_r, lpow_nxt;
  logic [6:0]                rpow_r, rpow_nxt;
  logic                      lfwd_r, lfwd_nxt;
  logic                      rfwd_r, rfwd_nxt;
  logic                      rev_r, rev_nxt;
  logic [11:0]               sp_r, sp_nxt;
  logic [ODOMETER_WIDTH-1:0] odo_r, odo_nxt;
  logic [3:0]                pins_r, pins_nxt;  // m1_pos, m1_neg, m2_pos, m2_neg

  // tick datapath
  logic [7:0] phase_sum;
  logic [6:0] phase_wrap;
  logic [6:0] phase_tick;
  logic [7:0] pow_sum;
  logic       on_l, on_r;

  // sample datapath: distances are signed, 15 bits cover 3000 - 8191 .. 3000
  logic signed [14:0] dist_l, dist_r, near_l, near_r, margin_s;
  logic signed [17:0] far_lhs, far_rhs, near_lhs, near_rhs;
  logic               beacon_seen;

  // command datapath
  logic [12:0] sp_up;

  always_comb begin
    // phase step; the add keeps seven bits, anything above 99 wraps to zero
    phase_sum  = {1'b0, phase_r} + STEP8;
    phase_wrap = phase_sum[6:0];
    phase_tick = (phase_wrap > PHASE_TOP) ? 7'd0 : phase_wrap;
    pow_sum    = {1'b0, lpow_r} + {1'b0, rpow_r};
    on_l       = lpow_r > phase_tick;
    on_r       = rpow_r > phase_tick;

    // sensor distances, sides swapped when the car runs reversed
    dist_l   = $signed(SENSE_BASE) - $signed({2'b00, s1_item_r.left_sensor_mv});
    dist_r   = $signed(SENSE_BASE) - $signed({2'b00, s1_item_r.right_sensor_mv});
    near_l   = rev_r ? dist_r : dist_l;
    near_r   = rev_r ? dist_l : dist_r;
    margin_s = $signed({3'b000, turn_margin_r});
    // ratio tests: far when 5*l > 6*sp, near when 6*l < 5*sp
    far_lhs  = 18'(near_l) * 18'sd5;
    far_rhs  = $signed({6'd0, sp_r}) * 18'sd6;
    near_lhs = 18'(near_l) * 18'sd6;
    near_rhs = $signed({6'd0, sp_r}) * 18'sd5;
    beacon_seen = s1_item_r.beacon_mv > beacon_threshold_r;

    sp_up = {1'b0, sp_r} + {1'b0, setpoint_step_r};

    phase_nxt = phase_r;
    lpow_nxt  = lpow_r;
    rpow_nxt  = rpow_r;
    lfwd_nxt  = lfwd_r;
    rfwd_nxt  = rfwd_r;
    rev_nxt   = rev_r;
    sp_nxt    = sp_r;
    odo_nxt   = odo_r;
    pins_nxt  = pins_r;

    unique case (s1_item_r.mode)
      MODE_TICK: begin
        phase_nxt = phase_tick;
        if (phase_wrap > PHASE_TOP) begin
          odo_nxt = odo_r + ODOMETER_WIDTH'(odo_increment(pow_sum[7:1]));
        end
        // bridge mapping depends on orientation
        if (rev_r) begin
          pins_nxt = {on_l & lfwd_r, on_l & ~lfwd_r, on_r & rfwd_r, on_r & ~rfwd_r};
        end else begin
          pins_nxt = {on_r & ~rfwd_r, on_r & rfwd_r, on_l & ~lfwd_r, on_l & lfwd_r};
        end
      end
      MODE_SAMPLE: begin
        if (!beacon_seen) begin
          lpow_nxt = 7'd0;
          rpow_nxt = 7'd0;
        end else if (near_l > near_r + margin_s) begin
          rpow_nxt = 7'd0;
          lpow_nxt = follow_power_r;
        end else if (near_r > near_l + margin_s) begin
          lpow_nxt = 7'd0;
          rpow_nxt = follow_power_r;
        end else if (far_lhs > far_rhs) begin
          lfwd_nxt = 1'b1;
          rfwd_nxt = 1'b1;
          lpow_nxt = follow_power_r;
          rpow_nxt = follow_power_r;
        end else if (near_lhs < near_rhs) begin
          lfwd_nxt = 1'b0;
          rfwd_nxt = 1'b0;
          lpow_nxt = follow_power_r;
          rpow_nxt = follow_power_r;
        end else begin
          lpow_nxt = 7'd0;
          rpow_nxt = 7'd0;
        end
      end
      MODE_COMMAND: begin
        case (s1_item_r.command_code)
          CMD_FLIP: begin
            lfwd_nxt = 1'b1;
            rfwd_nxt = 1'b0;
            rev_nxt  = ~rev_r;
            lpow_nxt = 7'd0;
            rpow_nxt = 7'd0;
          end
          CMD_CLOSER: begin
            if (sp_r > setpoint_min_r) begin
              sp_nxt = (sp_r > setpoint_step_r) ? sp_r - setpoint_step_r : 12'd0;
            end
          end
          CMD_FARTHER: begin
            if (sp_r < setpoint_max_r) begin
              sp_nxt = (sp_up > {1'b0, SETPOINT_LIMIT}) ? SETPOINT_LIMIT : sp_up[11:0];
            end
          end
          CMD_PARK: begin
            lfwd_nxt = 1'b0;
            rfwd_nxt = 1'b0;
            lpow_nxt = 7'd0;
            rpow_nxt = 7'd0;
          end
          default: ;  // unknown codes leave the state alone
        endcase
      end
      default: ;  // no-op request still produces a result
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 7'd0;
      lpow_r  <= 7'd0;
      rpow_r  <= 7'd0;
      lfwd_r  <= 1'b0;
      rfwd_r  <= 1'b0;
      rev_r   <= 1'b0;
      sp_r    <= SETPOINT_RESET;
      odo_r   <= '0;
      pins_r  <= 4'd0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      lpow_r  <= lpow_nxt;
      rpow_r  <= rpow_nxt;
      lfwd_r  <= lfwd_nxt;
      rfwd_r  <= rfwd_nxt;
      rev_r   <= rev_nxt;
      sp_r    <= sp_nxt;
      odo_r   <= odo_nxt;
      pins_r  <= pins_nxt;
    end
  end

  // ---------------- result register ----------------
  logic [63:0] odo_ext;
  assign odo_ext = 64'(odo_nxt);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r.m1_pos             <= pins_nxt[3];
      out_item_r.m1_neg             <= pins_nxt[2];
      out_item_r.m2_pos             <= pins_nxt[1];
      out_item_r.m2_neg             <= pins_nxt[0];
      out_item_r.left_power_out     <= lpow_nxt;
      out_item_r.right_power_out    <= rpow_nxt;
      out_item_r.left_forward_out   <= lfwd_nxt;
      out_item_r.right_forward_out  <= rfwd_nxt;
      out_item_r.reversed_out       <= rev_nxt;
      out_item_r.follow_setpoint    <= sp_nxt;
      out_item_r.distance_travelled <= odo_ext[31:0];
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.m1_pos             = out_item_r.m1_pos;
  assign out_chan.m1_neg             = out_item_r.m1_neg;
  assign out_chan.m2_pos             = out_item_r.m2_pos;
  assign out_chan.m2_neg             = out_item_r.m2_neg;
  assign out_chan.left_power_out     = out_item_r.left_power_out;
  assign out_chan.right_power_out    = out_item_r.right_power_out;
  assign out_chan.left_forward_out   = out_item_r.left_forward_out;
  assign out_chan.right_forward_out  = out_item_r.right_forward_out;
  assign out_chan.reversed_out       = out_item_r.reversed_out;
  assign out_chan.follow_setpoint    = out_item_r.follow_setpoint;
  assign out_chan.distance_travelled = out_item_r.distance_travelled;

  // ---------------- assertions ----------------
  // phase stays inside one pwm period
  `FTMPC_ASSERT_NOW(a_phase_range, 1'b1, phase_r <= PHASE_TOP, "pwm phase out of range")
  // every request leaving the input register lands in the result register
  `FTMPC_ASSERT_NEXT(a_adv_fills_out, adv, out_valid_r, "result register not loaded")
  // a tick never alters motor powers or directions
  `FTMPC_ASSERT_NEXT(a_tick_keeps_motor, adv && (s1_item_r.mode == MODE_TICK),
    $stable(lpow_r) && $stable(rpow_r) && $stable(lfwd_r) && $stable(rfwd_r),
    "tick changed motor state")
  // the input register never drops a request while stalled
  `FTMPC_ASSERT_NEXT(a_s1_holds, s1_valid_r && !adv, s1_valid_r, "stalled request lost")

endmodule
